// ----- sv/mse_pkg.sv -----
// mse_pkg: shared types and constants for the merge sort engine.
// Used by mse_front, mse_back, mse_outq and merge_sort_engine.
package mse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 32;
  localparam int Q_DEPTH   = 4;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_ITEMS);
  localparam logic [QCNT_W-1:0] Q_FULL_N = QCNT_W'(Q_DEPTH);

  // classified input item, front to back
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        idx;
    logic                    keep;
    logic                    last;
  } cmd_t;

  // one sorted result, back to result queue
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    fin;
    logic                    ovf;
  } res_t;

endpackage

// ----- sv/merge_sort_engine.sv -----
// Stable ascending sort of sets of up to 64 signed 32-bit values. Items enter
// one per cycle while not full through a 4-entry command queue; elements past
// 64 are dropped and flag overflow on every result of that set. The item marked
// last starts the sort: ceil(log2 n) merge passes, each a setup step per run pair
// and then one merge step per cycle (set by the two-read-port ping-pong memories),
// then a read setup step and the result stream, which pauses while the result
// queue is full. A set of one goes straight to output.
// Depends on mse_pkg, mse_front, mse_back and mse_outq.
module merge_sort_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [mse_pkg::VAL_W-1:0]  value,
  input  logic                              last,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mse_pkg::VAL_W-1:0]  sorted_value,
  output logic                              final_res,
  output logic                              overflow
);

  logic           cmd_valid;
  logic           cmd_pop;
  mse_pkg::cmd_t  cmd;
  logic           res_full;
  logic           res_push;
  mse_pkg::res_t  res;
  mse_pkg::res_t  head;

  mse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .last      (last),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  mse_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign sorted_value = head.value;
  assign final_res    = head.fin;
  assign overflow     = head.ovf;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

// ----- sv/mse_front.sv -----
// mse_front: input side; tags each item with its store slot or a drop mark
// and buffers it in a short command queue. Depends on mse_pkg.
module mse_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [mse_pkg::VAL_W-1:0]  value,
  input  logic                              last,
  output logic                              cmd_valid,
  output mse_pkg::cmd_t                     cmd,
  input  logic                              cmd_pop
);

  mse_pkg::cmd_t                 q [mse_pkg::Q_DEPTH];
  logic [mse_pkg::QPTR_W-1:0]    wp;
  logic [mse_pkg::QPTR_W-1:0]    rp;
  logic [mse_pkg::QCNT_W-1:0]    qcnt;
  logic [mse_pkg::CNT_W-1:0]     set_cnt;
  logic                          acc;
  logic                          keep;
  mse_pkg::cmd_t                 item;

  assign full      = (qcnt == mse_pkg::Q_FULL_N);
  assign cmd_valid = (qcnt != '0);
  assign cmd       = q[rp];
  assign acc       = push && !full;
  assign keep      = (set_cnt < mse_pkg::MAX_CNT);

  always_comb begin
    item.value = value;
    item.idx   = set_cnt[mse_pkg::IDX_W-1:0];
    item.keep  = keep;
    item.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      qcnt    <= '0;
      set_cnt <= '0;
    end else begin
      if (acc) begin
        wp <= wp + 1'b1;
        if (last) begin
          set_cnt <= '0;
        end else if (keep) begin
          set_cnt <= set_cnt + 1'b1;
        end
      end
      if (cmd_pop) begin
        rp <= rp + 1'b1;
      end
      case ({acc, cmd_pop})
        2'b10:   qcnt <= qcnt + 1'b1;
        2'b01:   qcnt <= qcnt - 1'b1;
        default: qcnt <= qcnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wp] <= item;
    end
  end

endmodule

// ----- sv/mse_outq.sv -----
// mse_outq: short result queue between the sort sequencer and the output
// ports. Depends on mse_pkg.
module mse_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_push,
  input  mse_pkg::res_t         res,
  output logic                  res_full,
  output logic                  empty,
  input  logic                  pop,
  output mse_pkg::res_t         head
);

  mse_pkg::res_t                 q [mse_pkg::Q_DEPTH];
  logic [mse_pkg::QPTR_W-1:0]    wp;
  logic [mse_pkg::QPTR_W-1:0]    rp;
  logic [mse_pkg::QCNT_W-1:0]    qcnt;
  logic                          wr;
  logic                          rd;

  assign res_full = (qcnt == mse_pkg::Q_FULL_N);
  assign empty    = (qcnt == '0);
  assign head     = q[rp];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      qcnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      case ({wr, rd})
        2'b10:   qcnt <= qcnt + 1'b1;
        2'b01:   qcnt <= qcnt - 1'b1;
        default: qcnt <= qcnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= res;
    end
  end

endmodule

// ----- sv/mse_back.sv -----
// mse_back: stores classified items, runs bottom-up merge passes between two
// ping-pong memories and streams the sorted set out. Depends on mse_pkg.
module mse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  mse_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output mse_pkg::res_t  res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_OPRE  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam int IW = mse_pkg::IDX_W;
  localparam int CW = mse_pkg::CNT_W;
  localparam int VW = mse_pkg::VAL_W;

  logic signed [VW-1:0] mem_a [mse_pkg::MAX_ITEMS];
  logic signed [VW-1:0] mem_b [mse_pkg::MAX_ITEMS];
  logic signed [VW-1:0] qa_a, qa_b, qb_a, qb_b;
  logic signed [VW-1:0] da, db, wdata;
  logic [IW-1:0]        ra, rb, waddr;
  logic                 we_a, we_b;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] n, n_next;
  logic          ovf_set, ovf_set_next;
  logic [CW-1:0] width, width_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] o, o_next;
  logic          src_sel, src_sel_next;

  logic [CW-1:0] cnt_inc, mid_c, hi_c, lo_w, lo_2w, width_2, k_inc, o_inc;
  logic          take_i;

  assign da      = src_sel ? qb_a : qa_a;
  assign db      = src_sel ? qb_b : qa_b;
  assign cnt_inc = count + CW'(cmd.keep);
  assign width_2 = width << 1;
  assign lo_w    = lo + width;
  assign lo_2w   = lo + width_2;
  assign mid_c   = (lo_w > n) ? n : lo_w;
  assign hi_c    = (lo_2w > n) ? n : lo_2w;
  assign take_i  = (i < mid) && ((j >= hi) || (da <= db));
  assign k_inc   = k + 1'b1;
  assign o_inc   = o + 1'b1;

  always_comb begin
    res.value = da;
    res.fin   = (o_inc == n);
    res.ovf   = ovf_set;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    n_next       = n;
    ovf_set_next = ovf_set;
    width_next   = width;
    lo_next      = lo;
    i_next       = i;
    j_next       = j;
    mid_next     = mid;
    hi_next      = hi;
    k_next       = k;
    o_next       = o;
    src_sel_next = src_sel;
    ra           = '0;
    rb           = '0;
    we_a         = 1'b0;
    we_b         = 1'b0;
    waddr        = '0;
    wdata        = '0;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          we_a  = cmd.keep;
          waddr = cmd.idx;
          wdata = cmd.value;
          if (cmd.last) begin
            n_next       = cnt_inc;
            ovf_set_next = ovf | !cmd.keep;
            count_next   = '0;
            ovf_next     = 1'b0;
            width_next   = CW'(1);
            lo_next      = '0;
            o_next       = '0;
            src_sel_next = 1'b0;
            state_next   = (cnt_inc > CW'(1)) ? S_SETUP : S_OPRE;
          end else begin
            count_next = cnt_inc;
            ovf_next   = ovf | !cmd.keep;
          end
        end
      end
      S_SETUP: begin
        ra         = lo[IW-1:0];
        rb         = mid_c[IW-1:0];
        i_next     = lo;
        j_next     = mid_c;
        mid_next   = mid_c;
        hi_next    = hi_c;
        k_next     = lo;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        we_a   = src_sel;
        we_b   = !src_sel;
        waddr  = k[IW-1:0];
        wdata  = take_i ? da : db;
        i_next = i + CW'(take_i);
        j_next = j + CW'(!take_i);
        ra     = i_next[IW-1:0];
        rb     = j_next[IW-1:0];
        k_next = k_inc;
        if (k_inc == hi) begin
          if (hi == n) begin
            width_next   = width_2;
            src_sel_next = !src_sel;
            lo_next      = '0;
            o_next       = '0;
            state_next   = (width_2 >= n) ? S_OPRE : S_SETUP;
          end else begin
            lo_next    = hi;
            state_next = S_SETUP;
          end
        end
      end
      S_OPRE: begin
        ra         = o[IW-1:0];
        state_next = S_OUT;
      end
      S_OUT: begin
        res_push = !res_full;
        if (!res_full) begin
          ra     = o_inc[IW-1:0];
          o_next = o_inc;
          if (o_inc == n) begin
            state_next = S_IDLE;
          end
        end else begin
          ra = o[IW-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    n       <= n_next;
    ovf_set <= ovf_set_next;
    width   <= width_next;
    lo      <= lo_next;
    i       <= i_next;
    j       <= j_next;
    mid     <= mid_next;
    hi      <= hi_next;
    k       <= k_next;
    o       <= o_next;
    src_sel <= src_sel_next;
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    qa_a <= mem_a[ra];
    qa_b <= mem_a[rb];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    qb_a <= mem_b[ra];
    qb_b <= mem_b[rb];
  end

endmodule
